// ----- src/stereo_softclip_auto_gain_top_macros.svh -----
// Assertion macros for the stereo soft clip and gain block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef STEREO_SOFTCLIP_AUTO_GAIN_TOP_MACROS_SVH
`define STEREO_SOFTCLIP_AUTO_GAIN_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define SSCAG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sscag assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define SSCAG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sscag assertion failed");
`else
`define SSCAG_ASSERT_IMP(label, ante, cons)
`define SSCAG_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- src/sscag_pkg.sv -----
`timescale 1ns / 1ps

package sscag_pkg;

  // Serial multiplier: multiplicand width, multiplier width, product width.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Serial divider: dividend and divisor widths.
  localparam int DIV_N_W = 52;
  localparam int DIV_D_W = 27;

  // Serial square root: radicand and root widths.
  localparam int SQ_IN_W  = 48;
  localparam int SQ_OUT_W = SQ_IN_W / 2;

  // Request kinds on the input channel.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FREEZE = 1'b1;

  localparam logic [24:0] ONE_Q24   = 25'd16777216;
  localparam logic [23:0] THREE_Q20 = 24'd3145728;
  localparam logic [25:0] C27_Q20   = 26'd28311552;
  localparam logic [23:0] TINY_Q24  = 24'd17;
  localparam logic [23:0] UNITY_Q22 = 24'd4194304;

  localparam logic [23:0] RST_ATTACK   = 24'd16776284;
  localparam logic [23:0] RST_NORM_REL = 24'd16776867;
  localparam logic [23:0] RST_FAST_REL = 24'd16773721;
  localparam logic [23:0] RST_TARGET   = 24'd8409135;
  localparam logic [23:0] RST_GATE     = 24'd16777;
  localparam logic [23:0] RST_FLOOR    = 24'd419430;
  localparam logic [23:0] RST_CEILING  = 24'd12582912;
  localparam logic [15:0] RST_FREEZE   = 16'd9600;

  typedef enum logic [2:0] {
    REG_ATTACK,
    REG_NORM_REL,
    REG_FAST_REL,
    REG_TARGET,
    REG_GATE,
    REG_FLOOR,
    REG_CEILING,
    REG_FREEZE
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAG,
    ST_SQ,
    ST_NUM,
    ST_DIV,
    ST_PWR_L,
    ST_PWR_R,
    ST_AVG_A,
    ST_AVG_B,
    ST_SQRT,
    ST_GATE,
    ST_TGT,
    ST_STEP,
    ST_OUT_L,
    ST_OUT_R,
    ST_DONE
  } seq_state_t;

endpackage

// ----- src/sscag_mul.sv -----
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle.
module sscag_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [sscag_pkg::MUL_A_W-1:0]    a,
  input  logic [sscag_pkg::MUL_B_W-1:0]    b,
  output logic                             done,
  output logic [sscag_pkg::MUL_P_W-1:0]    prod
);

  localparam int CNT_W = $clog2(sscag_pkg::MUL_B_W);

  logic [sscag_pkg::MUL_A_W-1:0] areg;
  logic [sscag_pkg::MUL_B_W-1:0] breg;
  logic [CNT_W-1:0]              cnt;
  logic                          busy;
  logic [sscag_pkg::MUL_A_W:0]   sum;

  assign sum = {1'b0, prod[sscag_pkg::MUL_P_W-1:sscag_pkg::MUL_B_W]}
             + (breg[0] ? {1'b0, areg} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        areg <= a;
        breg <= b;
        prod <= '0;
      end else if (busy) begin
        prod <= {sum, prod[sscag_pkg::MUL_B_W-1:1]};
        breg <= breg >> 1;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(sscag_pkg::MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/sscag_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module sscag_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sscag_pkg::DIV_N_W-1:0] dividend,
  input  logic [sscag_pkg::DIV_D_W-1:0] divisor,
  output logic                          done,
  output logic [sscag_pkg::DIV_N_W-1:0] quot
);

  localparam int CNT_W = $clog2(sscag_pkg::DIV_N_W);

  logic [sscag_pkg::DIV_D_W-1:0] dreg;
  logic [sscag_pkg::DIV_D_W-1:0] rem;
  logic [sscag_pkg::DIV_D_W:0]   trial;
  logic [sscag_pkg::DIV_D_W:0]   diff;
  logic                          ge;
  logic [CNT_W-1:0]              cnt;
  logic                          busy;

  assign trial = {rem, quot[sscag_pkg::DIV_N_W-1]};
  assign ge    = trial >= {1'b0, dreg};
  assign diff  = trial - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dreg <= divisor;
        rem  <= '0;
        quot <= dividend;
      end else if (busy) begin
        rem  <= ge ? diff[sscag_pkg::DIV_D_W-1:0] : trial[sscag_pkg::DIV_D_W-1:0];
        quot <= {quot[sscag_pkg::DIV_N_W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(sscag_pkg::DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/sscag_sqrt.sv -----
`timescale 1ns / 1ps

// Digit-by-digit integer square root, two radicand bits per cycle.
module sscag_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [sscag_pkg::SQ_IN_W-1:0]  radicand,
  output logic                           done,
  output logic [sscag_pkg::SQ_OUT_W-1:0] root
);

  localparam int REM_W = sscag_pkg::SQ_OUT_W + 2;
  localparam int CNT_W = $clog2(sscag_pkg::SQ_OUT_W);

  logic [sscag_pkg::SQ_IN_W-1:0] src;
  logic [REM_W-1:0]              rem;
  logic [REM_W+1:0]              cur;
  logic [REM_W+1:0]              trial;
  logic [REM_W+1:0]              diff;
  logic                          ge;
  logic [CNT_W-1:0]              cnt;
  logic                          busy;

  assign cur   = {rem, src[sscag_pkg::SQ_IN_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = cur >= trial;
  assign diff  = cur - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        src  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rem  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        root <= {root[sscag_pkg::SQ_OUT_W-2:0], ge};
        src  <= src << 2;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(sscag_pkg::SQ_OUT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/stereo_softclip_auto_gain_top.sv -----
`timescale 1ns / 1ps
// Stereo soft clipper with RMS automatic gain control.
// The input channel carries one request per cycle at most: cmd low is a stereo
// sample pair in Q4.20, cmd high is a freeze event that reloads the fast release
// countdown and produces no result. A request is taken when in_valid is high and
// in_stall is low; the block stalls its input while a sample is being processed.
// Each sample gives exactly one output request of two Q3.21 samples, held on
// left_out and right_out with out_valid until the receiver drops out_stall.
// Samples run one at a time through a shared bit-serial multiplier, a restoring
// divider and a square root unit. out_valid rises after the gain stage, or
// straight after the gate check when the level is below the gate; a channel
// whose input is beyond +-3.0 skips its clip arithmetic. The next sample can
// be taken once the previous result is loaded into the output register, and a
// freeze event does not stall the input. The finished result sits in an output
// register, so the next sample is accepted while it waits; a sample that
// finishes while the previous result is still stalled waits in its last step
// until the register frees.
// Synchronous reset restores the configuration registers to their documented defaults, clears
// the power average and the countdown, and sets the running gain to unity.
// Configuration writes are always accepted and should be issued only while idle.
module stereo_softclip_auto_gain_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [23:0] left_in,
  input  logic [23:0] right_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] left_out,
  output logic [23:0] right_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  // Configuration registers.
  logic [23:0] attack_coeff;
  logic [23:0] normal_release_coeff;
  logic [23:0] fast_release_coeff;
  logic [23:0] target_level;
  logic [23:0] gate_threshold;
  logic [23:0] gain_floor;
  logic [23:0] gain_ceiling;
  logic [15:0] freeze_span;

  // Persistent loop state.
  logic [31:0] power_average;
  logic [23:0] gain_now;
  logic [15:0] freeze_countdown;

  // Sequencer.
  sscag_pkg::seq_state_t state, state_next;
  logic run, run_next;
  logic ch;

  // Per-sample working registers.
  logic [23:0] left_s, right_s;
  logic [23:0] a_mag;
  logic [23:0] a2;
  logic [47:0] num;
  logic [24:0] c_l, c_r;
  logic        neg_l, neg_r;
  logic [48:0] sq_l;
  logic [31:0] pw;
  logic [55:0] avg_t;
  logic [23:0] rms;
  logic [23:0] tgt;
  logic [23:0] res_l, res_r;

  // Shared arithmetic units.
  logic                           mul_start, mul_done;
  logic [sscag_pkg::MUL_A_W-1:0]  mul_a;
  logic [sscag_pkg::MUL_B_W-1:0]  mul_b;
  logic [sscag_pkg::MUL_P_W-1:0]  mul_p;
  logic                           div_start, div_done;
  logic [sscag_pkg::DIV_N_W-1:0]  div_n;
  logic [sscag_pkg::DIV_D_W-1:0]  div_d;
  logic [sscag_pkg::DIV_N_W-1:0]  div_q;
  logic                           sqrt_start, sqrt_done;
  logic [sscag_pkg::SQ_IN_W-1:0]  sqrt_in;
  logic [sscag_pkg::SQ_OUT_W-1:0] sqrt_root;

  logic uses_mul, uses_div, uses_sqrt, fin;

  // Magnitude of the channel being clipped.
  logic [23:0] src_x;
  logic        src_neg;
  logic [23:0] src_mag;
  logic        src_sat;

  // Gain step operands.
  logic        up;
  logic [23:0] g_diff;
  logic [24:0] k_att;
  logic [24:0] k_sel;
  logic [23:0] rel_coeff;
  logic [23:0] rms_div;

  // Wide intermediate sums.
  logic [49:0] pw_sum;
  logic [57:0] avg_sum;
  logic [48:0] step_sum;
  logic [23:0] g_step;

  logic out_load;

  // Take a magnitude that is already rounded and shifted into place, apply the sign and
  // saturate to the signed 24-bit range.
  function automatic logic [23:0] sat_sign(input logic [24:0] r, input logic neg);
    logic [24:0] lim;
    if (neg) begin
      lim = (r > 25'd8388608) ? 25'd8388608 : r;
      sat_sign = 24'(~lim + 25'd1);
    end else begin
      lim = (r > 25'd8388607) ? 25'd8388607 : r;
      sat_sign = lim[23:0];
    end
  endfunction

  // Gated path: clipped value divided by eight, rounded half away from zero.
  function automatic logic [23:0] gated_out(input logic [24:0] c, input logic neg);
    logic [25:0] t;
    t = {1'b0, c} + 26'd4;
    gated_out = sat_sign(25'(t[25:3]), neg);
  endfunction

  // Gain path: (c * gain) >> 25, rounded half away from zero.
  function automatic logic [23:0] gain_out(input logic [48:0] m, input logic neg);
    logic [49:0] t;
    t = {1'b0, m} + (50'd1 << 24);
    gain_out = sat_sign(t[49:25], neg);
  endfunction

  sscag_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  sscag_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (div_q)
  );

  sscag_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_in),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != sscag_pkg::ST_IDLE);

  always_comb begin
    src_x   = ch ? right_s : left_s;
    src_neg = src_x[23];
    src_mag = src_neg ? (~src_x + 24'd1) : src_x;
    src_sat = src_mag >= sscag_pkg::THREE_Q20;
  end

  // Gain rises with the attack coefficient; it falls with the fast release
  // while the freeze countdown runs and with the normal release otherwise.
  always_comb begin
    up        = tgt > gain_now;
    g_diff    = up ? (tgt - gain_now) : (gain_now - tgt);
    rel_coeff = (freeze_countdown != 16'd0) ? fast_release_coeff : normal_release_coeff;
    k_att     = sscag_pkg::ONE_Q24 - {1'b0, attack_coeff};
    k_sel     = up ? k_att : (sscag_pkg::ONE_Q24 - {1'b0, rel_coeff});
    rms_div   = (rms > sscag_pkg::TINY_Q24) ? rms : sscag_pkg::TINY_Q24;
    pw_sum    = {1'b0, sq_l} + {1'b0, mul_p[48:0]};
    avg_sum   = {2'b00, avg_t} + mul_p + (58'd1 << 23);
    step_sum  = mul_p[48:0] + (49'd1 << 23);
    g_step    = step_sum[47:24];
  end

  // Operand selection for the shared units.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_n   = '0;
    div_d   = '0;
    sqrt_in = {power_average, 16'd0};
    case (state)
      sscag_pkg::ST_SQ: begin
        mul_a = 32'(a_mag);
        mul_b = 26'(a_mag);
      end
      sscag_pkg::ST_NUM: begin
        mul_a = 32'(a_mag);
        mul_b = sscag_pkg::C27_Q20 + 26'(a2);
      end
      sscag_pkg::ST_DIV: begin
        div_n = {num, 4'd0};
        div_d = 27'(sscag_pkg::C27_Q20) + {a2, 3'd0} + 27'(a2);
      end
      sscag_pkg::ST_PWR_L: begin
        mul_a = 32'(c_l);
        mul_b = 26'(c_l);
      end
      sscag_pkg::ST_PWR_R: begin
        mul_a = 32'(c_r);
        mul_b = 26'(c_r);
      end
      sscag_pkg::ST_AVG_A: begin
        mul_a = power_average;
        mul_b = 26'(attack_coeff);
      end
      sscag_pkg::ST_AVG_B: begin
        mul_a = pw;
        mul_b = 26'(k_att);
      end
      sscag_pkg::ST_TGT: begin
        div_n = 52'({target_level, 22'd0});
        div_d = 27'(rms_div);
      end
      sscag_pkg::ST_STEP: begin
        mul_a = 32'(g_diff);
        mul_b = 26'(k_sel);
      end
      sscag_pkg::ST_OUT_L: begin
        mul_a = 32'(c_l);
        mul_b = 26'(gain_now);
      end
      sscag_pkg::ST_OUT_R: begin
        mul_a = 32'(c_r);
        mul_b = 26'(gain_now);
      end
      default: begin
      end
    endcase
  end

  // Next state. A unit step launches its unit on entry and moves on when the
  // unit reports completion.
  always_comb begin
    uses_mul   = state inside {sscag_pkg::ST_SQ, sscag_pkg::ST_NUM, sscag_pkg::ST_PWR_L,
                               sscag_pkg::ST_PWR_R, sscag_pkg::ST_AVG_A, sscag_pkg::ST_AVG_B,
                               sscag_pkg::ST_STEP, sscag_pkg::ST_OUT_L, sscag_pkg::ST_OUT_R};
    uses_div   = state inside {sscag_pkg::ST_DIV, sscag_pkg::ST_TGT};
    uses_sqrt  = (state == sscag_pkg::ST_SQRT);
    fin        = run & ((uses_mul & mul_done) | (uses_div & div_done) |
                        (uses_sqrt & sqrt_done));
    mul_start  = uses_mul & ~run;
    div_start  = uses_div & ~run;
    sqrt_start = uses_sqrt & ~run;
    run_next   = (uses_mul | uses_div | uses_sqrt) & ~fin;
    out_load   = 1'b0;
    state_next = state;
    case (state)
      sscag_pkg::ST_IDLE: begin
        if (in_valid && cmd == sscag_pkg::CMD_SAMPLE) state_next = sscag_pkg::ST_MAG;
      end
      sscag_pkg::ST_MAG: begin
        if (!src_sat) state_next = sscag_pkg::ST_SQ;
        else if (ch) state_next = sscag_pkg::ST_PWR_L;
      end
      sscag_pkg::ST_SQ: begin
        if (fin) state_next = sscag_pkg::ST_NUM;
      end
      sscag_pkg::ST_NUM: begin
        if (fin) state_next = sscag_pkg::ST_DIV;
      end
      sscag_pkg::ST_DIV: begin
        if (fin) state_next = ch ? sscag_pkg::ST_PWR_L : sscag_pkg::ST_MAG;
      end
      sscag_pkg::ST_PWR_L: begin
        if (fin) state_next = sscag_pkg::ST_PWR_R;
      end
      sscag_pkg::ST_PWR_R: begin
        if (fin) state_next = sscag_pkg::ST_AVG_A;
      end
      sscag_pkg::ST_AVG_A: begin
        if (fin) state_next = sscag_pkg::ST_AVG_B;
      end
      sscag_pkg::ST_AVG_B: begin
        if (fin) state_next = sscag_pkg::ST_SQRT;
      end
      sscag_pkg::ST_SQRT: begin
        if (fin) state_next = sscag_pkg::ST_GATE;
      end
      sscag_pkg::ST_GATE: begin
        state_next = (rms < gate_threshold) ? sscag_pkg::ST_DONE : sscag_pkg::ST_TGT;
      end
      sscag_pkg::ST_TGT: begin
        if (fin) state_next = sscag_pkg::ST_STEP;
      end
      sscag_pkg::ST_STEP: begin
        if (fin) state_next = sscag_pkg::ST_OUT_L;
      end
      sscag_pkg::ST_OUT_L: begin
        if (fin) state_next = sscag_pkg::ST_OUT_R;
      end
      sscag_pkg::ST_OUT_R: begin
        if (fin) state_next = sscag_pkg::ST_DONE;
      end
      sscag_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = sscag_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sscag_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sscag_pkg::ST_IDLE;
      run   <= 1'b0;
    end else begin
      state <= state_next;
      run   <= run_next;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coeff         <= sscag_pkg::RST_ATTACK;
      normal_release_coeff <= sscag_pkg::RST_NORM_REL;
      fast_release_coeff   <= sscag_pkg::RST_FAST_REL;
      target_level         <= sscag_pkg::RST_TARGET;
      gate_threshold       <= sscag_pkg::RST_GATE;
      gain_floor           <= sscag_pkg::RST_FLOOR;
      gain_ceiling         <= sscag_pkg::RST_CEILING;
      freeze_span          <= sscag_pkg::RST_FREEZE;
    end else if (cfg_valid && cfg_ready) begin
      case (sscag_pkg::cfg_reg_t'(cfg_index))
        sscag_pkg::REG_ATTACK:   attack_coeff         <= cfg_data;
        sscag_pkg::REG_NORM_REL: normal_release_coeff <= cfg_data;
        sscag_pkg::REG_FAST_REL: fast_release_coeff   <= cfg_data;
        sscag_pkg::REG_TARGET:   target_level         <= cfg_data;
        sscag_pkg::REG_GATE:     gate_threshold       <= cfg_data;
        sscag_pkg::REG_FLOOR:    gain_floor           <= cfg_data;
        sscag_pkg::REG_CEILING:  gain_ceiling         <= cfg_data;
        sscag_pkg::REG_FREEZE:   freeze_span          <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Loop state: power average, running gain and freeze countdown.
  always_ff @(posedge clk) begin
    if (rst) begin
      power_average    <= '0;
      gain_now         <= sscag_pkg::UNITY_Q22;
      freeze_countdown <= '0;
    end else begin
      if (state == sscag_pkg::ST_IDLE && in_valid && cmd == sscag_pkg::CMD_FREEZE) begin
        freeze_countdown <= freeze_span;
      end
      if (state == sscag_pkg::ST_AVG_B && fin) begin
        power_average <= avg_sum[55:24];
      end
      if (state == sscag_pkg::ST_STEP && fin) begin
        gain_now <= up ? (gain_now + g_step) : (gain_now - g_step);
        if (freeze_countdown != 16'd0) freeze_countdown <= freeze_countdown - 16'd1;
      end
    end
  end

  // Working registers of the sample in flight.
  always_ff @(posedge clk) begin
    if (state == sscag_pkg::ST_IDLE && in_valid && cmd == sscag_pkg::CMD_SAMPLE) begin
      left_s  <= left_in;
      right_s <= right_in;
      ch      <= 1'b0;
    end
    case (state)
      sscag_pkg::ST_MAG: begin
        a_mag <= src_mag;
        if (ch) neg_r <= src_neg;
        else neg_l <= src_neg;
        if (src_sat) begin
          // Beyond +-3.0 the clip is a full-scale one.
          if (ch) c_r <= sscag_pkg::ONE_Q24;
          else c_l <= sscag_pkg::ONE_Q24;
          ch <= 1'b1;
        end
      end
      sscag_pkg::ST_SQ: begin
        if (fin) a2 <= mul_p[43:20];
      end
      sscag_pkg::ST_NUM: begin
        if (fin) num <= mul_p[47:0];
      end
      sscag_pkg::ST_DIV: begin
        if (fin) begin
          if (ch) c_r <= div_q[24:0];
          else c_l <= div_q[24:0];
          ch <= 1'b1;
        end
      end
      sscag_pkg::ST_PWR_L: begin
        if (fin) sq_l <= mul_p[48:0];
      end
      sscag_pkg::ST_PWR_R: begin
        if (fin) pw <= pw_sum[49] ? 32'hFFFF_FFFF : pw_sum[48:17];
      end
      sscag_pkg::ST_AVG_A: begin
        if (fin) avg_t <= mul_p[55:0];
      end
      sscag_pkg::ST_SQRT: begin
        if (fin) rms <= sqrt_root;
      end
      sscag_pkg::ST_GATE: begin
        res_l <= gated_out(c_l, neg_l);
        res_r <= gated_out(c_r, neg_r);
      end
      sscag_pkg::ST_TGT: begin
        // A floor above the ceiling wins for targets below the floor.
        if (fin) begin
          if (div_q < 52'(gain_floor)) tgt <= gain_floor;
          else if (div_q > 52'(gain_ceiling)) tgt <= gain_ceiling;
          else tgt <= div_q[23:0];
        end
      end
      sscag_pkg::ST_OUT_L: begin
        if (fin) res_l <= gain_out(mul_p[48:0], neg_l);
      end
      sscag_pkg::ST_OUT_R: begin
        if (fin) res_r <= gain_out(mul_p[48:0], neg_r);
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_out  <= res_l;
      right_out <= res_r;
    end
  end

`include "stereo_softclip_auto_gain_top_macros.svh"

  // A result only appears from the final step of a sample.
  `SSCAG_ASSERT_IMP(a_out_from_done, $rose(out_valid), $past(state) == sscag_pkg::ST_DONE)
  // No arithmetic unit is left marked as launched once the sequencer is idle.
  `SSCAG_ASSERT_IMP(a_idle_no_run, state == sscag_pkg::ST_IDLE, !run)
  // An accepted sample starts the clip of the left channel.
  `SSCAG_ASSERT_NXT(a_sample_starts, in_valid && !in_stall && cmd == sscag_pkg::CMD_SAMPLE, state == sscag_pkg::ST_MAG)

endmodule
